// ----- hdl/keyed_item_table_core_assert.svh -----
`ifndef KEYED_ITEM_TABLE_CORE_ASSERT_SVH
`define KEYED_ITEM_TABLE_CORE_ASSERT_SVH

// same-cycle implication on clk, quiet in reset
`define KIT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, quiet in reset
`define KIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/kit_pkg.sv -----
package kit_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int KEY_W = 256;
  localparam int TAG_W = 192;
  localparam int AMT_IN_W = 32;
  localparam int AMT_W = 31;
  localparam int POS_W = 4;
  localparam int FILL_W = 5;
  localparam int KEY_BYTES = KEY_W / 8;

  localparam int S_TDATA_W = 480;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 488;
  localparam int M_TUSER_W = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_EMPTY_NAME  = 3'd2,
    ST_EMPTY_TYPE  = 3'd3,
    ST_NEGATIVE    = 3'd4,
    ST_TABLE_EMPTY = 3'd5,
    ST_NOT_FOUND   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    POS_ZERO = 2'd0,
    POS_IDX  = 2'd1,
    POS_HIT  = 2'd2
  } pos_sel_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [AMT_W-1:0] amt;
  } entry_t;

  typedef struct packed {
    logic     load_in;
    logic     idx_clr;
    logic     idx_inc;
    logic     rd_en;
    logic     rd_next;
    logic     wr_ins;
    logic     wr_shift;
    logic     cnt_dec;
    logic     hit_save;
    logic     out_load;
    status_t  out_status;
    pos_sel_t out_pos;
    logic     out_entry;
    logic     out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic cnt_zero;
    logic full;
    logic key_empty;
    logic tag_empty;
    logic amt_neg;
    logic match;
    logic idx_last;
    logic idx_next_last;
    logic out_free;
  } dp_stat_t;

  // zero every byte from the first zero byte on
  function automatic logic [KEY_W-1:0] clean_text(input logic [KEY_W-1:0] w);
    logic [KEY_BYTES-1:0] is_zero;
    logic [KEY_BYTES-1:0] ended;
    logic [KEY_W-1:0] v;
    for (int b = 0; b < KEY_BYTES; b++) begin
      is_zero[b] = (w[8*b +: 8] == 8'd0);
    end
    ended[0] = is_zero[0];
    for (int b = 1; b < KEY_BYTES; b++) begin
      ended[b] = ended[b-1] | is_zero[b];
    end
    for (int b = 0; b < KEY_BYTES; b++) begin
      v[8*b +: 8] = ended[b] ? 8'd0 : w[8*b +: 8];
    end
    return v;
  endfunction

endpackage

// ----- hdl/kit_ctrl.sv -----
module kit_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  kit_pkg::dp_stat_t   stat,
  output kit_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EMIT,
    S_LIST_RD,
    S_LIST_OUT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  state_t state, state_next;
  kit_pkg::status_t  res_status, res_status_next;
  kit_pkg::pos_sel_t res_pos, res_pos_next;
  logic res_entry, res_entry_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= kit_pkg::ST_OK;
      res_pos    <= kit_pkg::POS_ZERO;
      res_entry  <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_pos    <= res_pos_next;
      res_entry  <= res_entry_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    res_entry_next  = res_entry;
    cmd             = '0;
    cmd.out_status  = kit_pkg::ST_OK;
    cmd.out_pos     = kit_pkg::POS_ZERO;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_pos_next   = kit_pkg::POS_ZERO;
        res_entry_next = 1'b0;
        unique case (stat.op)
          kit_pkg::OP_INSERT: begin
            state_next = S_EMIT;
            if (stat.full) begin
              res_status_next = kit_pkg::ST_FULL;
            end else if (stat.key_empty) begin
              res_status_next = kit_pkg::ST_EMPTY_NAME;
            end else if (stat.tag_empty) begin
              res_status_next = kit_pkg::ST_EMPTY_TYPE;
            end else if (stat.amt_neg) begin
              res_status_next = kit_pkg::ST_NEGATIVE;
            end else begin
              res_status_next = kit_pkg::ST_OK;
              cmd.wr_ins      = 1'b1;
            end
          end
          kit_pkg::OP_LIST: begin
            if (stat.cnt_zero) begin
              res_status_next = kit_pkg::ST_TABLE_EMPTY;
              state_next      = S_EMIT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = S_LIST_RD;
            end
          end
          kit_pkg::OP_REMOVE, kit_pkg::OP_SEARCH: begin
            if (stat.cnt_zero) begin
              res_status_next = kit_pkg::ST_TABLE_EMPTY;
              state_next      = S_EMIT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = S_SRCH_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_status;
          cmd.out_pos    = res_pos;
          cmd.out_entry  = res_entry;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_LIST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = kit_pkg::ST_OK;
          cmd.out_pos    = kit_pkg::POS_IDX;
          cmd.out_entry  = 1'b1;
          cmd.out_last   = stat.idx_last;
          if (stat.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_LIST_RD;
          end
        end
      end
      S_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          cmd.hit_save    = 1'b1;
          res_status_next = kit_pkg::ST_OK;
          res_pos_next    = kit_pkg::POS_HIT;
          if (stat.op == kit_pkg::OP_SEARCH) begin
            res_entry_next = 1'b1;
            state_next     = S_EMIT;
          end else if (stat.idx_last) begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_EMIT;
          end else begin
            state_next = S_SHIFT_RD;
          end
        end else if (stat.idx_last) begin
          res_status_next = kit_pkg::ST_NOT_FOUND;
          state_next      = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_next = 1'b1;
        state_next  = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        if (stat.idx_next_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SHIFT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/kit_dp.sv -----
module kit_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  kit_pkg::ctrl_cmd_t            cmd,
  output kit_pkg::dp_stat_t             stat,
  input  kit_pkg::op_t                  in_op,
  input  logic [kit_pkg::KEY_W-1:0]     in_key,
  input  logic [kit_pkg::TAG_W-1:0]     in_tag,
  input  logic signed [kit_pkg::AMT_IN_W-1:0] in_amt,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output kit_pkg::status_t              out_status,
  output logic [kit_pkg::POS_W-1:0]     out_pos,
  output logic [kit_pkg::FILL_W-1:0]    out_fill,
  output kit_pkg::entry_t               out_entry,
  output logic                          out_last
);

  kit_pkg::entry_t mem [kit_pkg::CAPACITY];

  kit_pkg::op_t                      op_r;
  logic [kit_pkg::KEY_W-1:0]         key_r;
  logic [kit_pkg::TAG_W-1:0]         tag_r;
  logic signed [kit_pkg::AMT_IN_W-1:0] amt_r;
  logic [kit_pkg::CNT_W-1:0]         count;
  logic [kit_pkg::IDX_W-1:0]         idx;
  logic [kit_pkg::IDX_W-1:0]         hit;
  kit_pkg::entry_t                   rd_data;

  logic [kit_pkg::IDX_W-1:0] rd_addr;
  logic [kit_pkg::IDX_W-1:0] wr_addr;
  kit_pkg::entry_t           wr_data;
  logic                      wr_en;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_op;
      key_r <= kit_pkg::clean_text(in_key);
      tag_r <= kit_pkg::TAG_W'(kit_pkg::clean_text(kit_pkg::KEY_W'(in_tag)));
      amt_r <= in_amt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_ins) begin
      count <= count + kit_pkg::CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - kit_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + kit_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_save) begin
      hit <= idx;
    end
  end

  assign rd_addr = cmd.rd_next ? (idx + kit_pkg::IDX_W'(1)) : idx;
  assign wr_en   = cmd.wr_ins | cmd.wr_shift;
  assign wr_addr = cmd.wr_ins ? count[kit_pkg::IDX_W-1:0] : idx;
  always_comb begin
    if (cmd.wr_ins) begin
      wr_data.key = key_r;
      wr_data.tag = tag_r;
      wr_data.amt = amt_r[kit_pkg::AMT_W-1:0];
    end else begin
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign stat.op            = op_r;
  assign stat.cnt_zero      = (count == '0);
  assign stat.full          = (count == kit_pkg::CNT_W'(kit_pkg::CAPACITY));
  assign stat.key_empty     = (key_r[7:0] == 8'd0);
  assign stat.tag_empty     = (tag_r[7:0] == 8'd0);
  assign stat.amt_neg       = amt_r[kit_pkg::AMT_IN_W-1];
  assign stat.match         = (rd_data.key == key_r);
  assign stat.idx_last      = ((kit_pkg::CNT_W'(idx) + kit_pkg::CNT_W'(1)) == count);
  assign stat.idx_next_last = (((kit_pkg::CNT_W+1)'(idx) + (kit_pkg::CNT_W+1)'(2))
                               == {1'b0, count});
  assign stat.out_free      = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      out_fill   <= kit_pkg::FILL_W'(count);
      out_last   <= cmd.out_last;
      out_entry  <= cmd.out_entry ? rd_data : '0;
      case (cmd.out_pos)
        kit_pkg::POS_IDX: out_pos <= kit_pkg::POS_W'(idx);
        kit_pkg::POS_HIT: out_pos <= kit_pkg::POS_W'(hit);
        default:          out_pos <= '0;
      endcase
    end
  end

endmodule

// ----- hdl/keyed_item_table_core.sv -----
// insert: the word is checked in the dispatch state, then the emit state loads the result register
// search and remove: each scanned entry is read, then compared; remove moves later entries down
// list: each entry is read, then waits for the result register to be free before it is loaded
// one table operation at a time, paced by the entry memory and the result register
// reset clears the entry count and the result handshake; entry memory contents are kept
module keyed_item_table_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // key_word0, key_word1, key_word2, key_word3, tag_word0, tag_word1, tag_word2, amount_in
  input  logic [kit_pkg::S_TDATA_W-1:0]   s_tdata,
  // operation
  input  logic [kit_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // position, fill_count, out_key0..3, out_tag0..2, amount_out
  output logic [kit_pkg::M_TDATA_W-1:0]   m_tdata,
  // status
  output logic [kit_pkg::M_TUSER_W-1:0]   m_tuser,
  output logic                            m_tlast
);

  kit_pkg::ctrl_cmd_t cmd;
  kit_pkg::dp_stat_t  stat;

  kit_pkg::status_t                  out_status;
  logic [kit_pkg::POS_W-1:0]         out_pos;
  logic [kit_pkg::FILL_W-1:0]        out_fill;
  kit_pkg::entry_t                   out_entry;
  kit_pkg::op_t                      in_op;
  logic                              out_last_w;

  assign in_op = kit_pkg::op_t'(s_tuser);

  kit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kit_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_op),
    .in_key     (s_tdata[255:0]),
    .in_tag     (s_tdata[447:256]),
    .in_amt     (s_tdata[479:448]),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .out_status (out_status),
    .out_pos    (out_pos),
    .out_fill   (out_fill),
    .out_entry  (out_entry),
    .out_last   (out_last_w)
  );

  assign m_tdata = {out_entry.amt, out_entry.tag, out_entry.key, out_fill, out_pos};
  assign m_tuser = out_status;
  assign m_tlast = out_last_w;

endmodule

// ----- hdl/kit_checker.sv -----
`include "keyed_item_table_core_assert.svh"

module kit_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [kit_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [kit_pkg::M_TUSER_W-1:0] m_tuser,
  input logic                          m_tlast
);

  logic err_word;

  assign err_word = m_tvalid && (m_tuser != kit_pkg::ST_OK);

  `KIT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result word changed while stalled")
  `KIT_ASSERT(a_err_last, err_word, m_tlast, "error word not marked last")
  `KIT_ASSERT(a_err_zero, err_word, m_tdata[kit_pkg::M_TDATA_W-1:9] == '0, "error word carries entry data")
  `KIT_ASSERT(a_list_busy, m_tvalid && !m_tlast, !s_tready, "input taken while a list is still running")
  `KIT_ASSERT_NXT(a_in_busy, s_tvalid && s_tready, !s_tready, "input ready held after a word was taken")

endmodule

bind keyed_item_table_core kit_checker u_kit_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 135;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    kit_pkg::op_t op;
    logic [255:0] key;
    logic [191:0] tag;
    logic [31:0]  amt;
    logic         hold;
    logic         calm;
  } table_req_t;

  typedef struct packed {
    kit_pkg::status_t status;
    logic [3:0]       pos;
    logic [4:0]       fill;
    logic [3:0][63:0] key;
    logic [2:0][63:0] tag;
    logic [30:0]      qty;
    logic             last;
  } table_reply_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [kit_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [kit_pkg::S_TUSER_W-1:0] s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [kit_pkg::M_TDATA_W-1:0] m_tdata;
  logic [kit_pkg::M_TUSER_W-1:0] m_tuser;
  logic                          m_tlast;

  keyed_item_table_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // shadow copy of the table
  logic [255:0] name_mem [kit_pkg::CAPACITY];
  logic [191:0] kind_mem [kit_pkg::CAPACITY];
  logic [30:0]  qty_mem  [kit_pkg::CAPACITY];
  int           fill_level = 0;

  table_req_t   pending_reqs [$];
  table_reply_t table_replies_due [$];
  table_req_t   cur_req;
  table_reply_t want;
  table_reply_t got;

  logic         calm = 1'b0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           errors = 0;
  int           words_seen = 0;
  int           reqs_taken = 0;
  int           op_count [4] = '{0, 0, 0, 0};
  int           rejects = 0;
  int           misses = 0;
  int           cycle_count = 0;

  logic [255:0] name_pool [8];
  int           pool_len [8];

  function automatic logic [255:0] zero_after_nul(input logic [255:0] w);
    logic [255:0] v;
    bit           done;
    v = '0;
    done = 1'b0;
    for (int b = 0; b < 32; b++) begin
      if (w[8*b +: 8] == 8'd0) done = 1'b1;
      if (!done) v[8*b +: 8] = w[8*b +: 8];
    end
    return v;
  endfunction

  function automatic logic [255:0] text_of(input int len, input bit junk);
    logic [255:0] v;
    v = '0;
    for (int b = 0; b < 32; b++) begin
      if (b < len) v[8*b +: 8] = 8'($urandom_range(1, 255));
      else if (b > len && junk) v[8*b +: 8] = 8'($urandom_range(0, 255));
    end
    return v;
  endfunction

  function automatic logic [191:0] tag_of(input int len, input bit junk);
    logic [255:0] v;
    v = text_of(len, junk);
    return v[191:0];
  endfunction

  // random bytes after the terminator of a clean name
  function automatic logic [255:0] with_junk(input logic [255:0] w, input int len);
    logic [255:0] v;
    v = w;
    for (int b = len + 1; b < 32; b++) v[8*b +: 8] = 8'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic void apply_table_op(input table_req_t r);
    logic [255:0]     k;
    logic [255:0]     wide;
    logic [191:0]     t;
    table_reply_t     w;
    kit_pkg::status_t st;
    int               hit;
    k = zero_after_nul(r.key);
    wide = zero_after_nul({64'd0, r.tag});
    t = wide[191:0];
    w = '0;
    w.last = 1'b1;
    op_count[r.op]++;
    case (r.op)
      kit_pkg::OP_INSERT: begin
        if (fill_level >= kit_pkg::CAPACITY) st = kit_pkg::ST_FULL;
        else if (k[7:0] == 8'd0) st = kit_pkg::ST_EMPTY_NAME;
        else if (t[7:0] == 8'd0) st = kit_pkg::ST_EMPTY_TYPE;
        else if (r.amt[31]) st = kit_pkg::ST_NEGATIVE;
        else begin
          name_mem[fill_level] = k;
          kind_mem[fill_level] = t;
          qty_mem[fill_level] = r.amt[30:0];
          fill_level++;
          st = kit_pkg::ST_OK;
        end
        if (st != kit_pkg::ST_OK) rejects++;
        w.status = st;
        w.fill = fill_level[4:0];
        table_replies_due.push_back(w);
      end
      kit_pkg::OP_LIST: begin
        if (fill_level == 0) begin
          w.status = kit_pkg::ST_TABLE_EMPTY;
          table_replies_due.push_back(w);
        end else begin
          for (int i = 0; i < fill_level; i++) begin
            w = '0;
            w.status = kit_pkg::ST_OK;
            w.pos = i[3:0];
            w.fill = fill_level[4:0];
            w.key = name_mem[i];
            w.tag = kind_mem[i];
            w.qty = qty_mem[i];
            w.last = (i == fill_level - 1);
            table_replies_due.push_back(w);
          end
        end
      end
      default: begin
        hit = -1;
        for (int i = 0; i < fill_level; i++) begin
          if (hit < 0 && name_mem[i] == k) hit = i;
        end
        if (fill_level == 0) begin
          w.status = kit_pkg::ST_TABLE_EMPTY;
        end else if (hit < 0) begin
          w.status = kit_pkg::ST_NOT_FOUND;
          misses++;
        end else if (r.op == kit_pkg::OP_SEARCH) begin
          w.status = kit_pkg::ST_OK;
          w.pos = hit[3:0];
          w.key = name_mem[hit];
          w.tag = kind_mem[hit];
          w.qty = qty_mem[hit];
        end else begin
          for (int i = hit; i + 1 < fill_level; i++) begin
            name_mem[i] = name_mem[i+1];
            kind_mem[i] = kind_mem[i+1];
            qty_mem[i] = qty_mem[i+1];
          end
          fill_level--;
          w.status = kit_pkg::ST_OK;
          w.pos = hit[3:0];
        end
        w.fill = fill_level[4:0];
        table_replies_due.push_back(w);
      end
    endcase
  endfunction

  function automatic int field_diff(input string name, input logic [63:0] exp_v,
                                    input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  task automatic queue_req(input kit_pkg::op_t op, input logic [255:0] key,
                           input logic [191:0] tag, input logic [31:0] amt,
                           input bit hold, input bit quiet);
    table_req_t r;
    r.op = op;
    r.key = key;
    r.tag = tag;
    r.amt = amt;
    r.hold = hold;
    r.calm = quiet;
    pending_reqs.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_table_op(cur_req);
        reqs_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (pending_reqs[0].hold && table_replies_due.size() != 0) begin
          s_tvalid <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          s_tdata <= {cur_req.amt, cur_req.tag, cur_req.key};
          s_tuser <= cur_req.op;
          s_tvalid <= 1'b1;
          calm <= cur_req.calm;
          if (!cur_req.calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 6);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = kit_pkg::status_t'(m_tuser);
        got.pos = m_tdata[3:0];
        got.fill = m_tdata[8:4];
        got.key = m_tdata[264:9];
        got.tag = m_tdata[456:265];
        got.qty = m_tdata[487:457];
        got.last = m_tlast;
        words_seen++;
        if (table_replies_due.size() == 0) begin
          $error("result word with no request pending");
          errors++;
        end else begin
          want = table_replies_due.pop_front();
          errors += field_diff("status", 64'(want.status), 64'(got.status));
          errors += field_diff("position", 64'(want.pos), 64'(got.pos));
          errors += field_diff("fill_count", 64'(want.fill), 64'(got.fill));
          for (int j = 0; j < 4; j++) begin
            errors += field_diff($sformatf("out_key%0d", j), want.key[j], got.key[j]);
          end
          for (int j = 0; j < 3; j++) begin
            errors += field_diff($sformatf("out_tag%0d", j), want.tag[j], got.tag[j]);
          end
          errors += field_diff("amount_out", 64'(want.qty), 64'(got.qty));
          errors += field_diff("last", 64'(want.last), 64'(got.last));
        end
      end
      if (calm) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [255:0] name_a;
    logic [255:0] name_b;
    logic [255:0] key;
    logic [191:0] tag;
    logic [31:0]  amt;
    kit_pkg::op_t op;
    int           pick;
    int           p;
    int           r;

    // directed: empty table, insert checks, fill to capacity, lookups
    name_a = text_of(5, 0);
    name_b = name_a;
    name_b[39:32] = 8'd0;
    queue_req(kit_pkg::OP_LIST, '0, '0, '0, 0, 0);
    queue_req(kit_pkg::OP_SEARCH, name_a, '0, '0, 0, 0);
    queue_req(kit_pkg::OP_REMOVE, name_a, '0, '0, 0, 0);
    queue_req(kit_pkg::OP_INSERT, text_of(0, 1), tag_of(4, 0), 32'd1, 0, 0);
    queue_req(kit_pkg::OP_INSERT, name_a, tag_of(0, 1), 32'd1, 0, 0);
    queue_req(kit_pkg::OP_INSERT, name_a, tag_of(3, 0), 32'h8000_0000, 0, 0);
    queue_req(kit_pkg::OP_INSERT, '1, '1, 32'h7FFF_FFFF, 0, 0);
    queue_req(kit_pkg::OP_INSERT, with_junk(name_a, 5), tag_of(6, 1), 32'd0, 0, 0);
    for (int i = 0; i < kit_pkg::CAPACITY - 2; i++) begin
      queue_req(kit_pkg::OP_INSERT, text_of($urandom_range(1, 32), 1),
                tag_of($urandom_range(1, 24), 1), {1'b0, 31'($urandom)}, 0, 0);
    end
    queue_req(kit_pkg::OP_INSERT, '0, '0, 32'hFFFF_FFFF, 0, 0);
    queue_req(kit_pkg::OP_LIST, '0, '0, '0, 1, 0);
    queue_req(kit_pkg::OP_SEARCH, with_junk(name_a, 5), '0, '0, 0, 0);
    queue_req(kit_pkg::OP_SEARCH, name_b, '0, '0, 0, 0);
    queue_req(kit_pkg::OP_REMOVE, '1, '0, '0, 0, 0);

    // pool of names, odd entries are prefixes of the one before
    for (int i = 0; i < 8; i++) begin
      if (i == 0) begin
        pool_len[i] = 32;
        name_pool[i] = text_of(32, 0);
      end else if (i % 2 == 1) begin
        pool_len[i] = $urandom_range(1, pool_len[i-1]);
        name_pool[i] = name_pool[i-1];
        for (int b = pool_len[i]; b < 32; b++) name_pool[i][8*b +: 8] = 8'd0;
      end else begin
        pool_len[i] = $urandom_range(1, 32);
        name_pool[i] = text_of(pool_len[i], 0);
      end
    end

    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) op = kit_pkg::OP_INSERT;
      else if (pick < 55) op = kit_pkg::OP_REMOVE;
      else if (pick < 85) op = kit_pkg::OP_SEARCH;
      else op = kit_pkg::OP_LIST;
      p = $urandom_range(0, 7);
      if ($urandom_range(0, 6) == 0) key = text_of($urandom_range(0, 32), $urandom_range(0, 1));
      else if ($urandom_range(0, 1) == 0) key = with_junk(name_pool[p], pool_len[p]);
      else key = name_pool[p];
      if ($urandom_range(0, 19) == 0) tag = tag_of(0, 1);
      else tag = tag_of($urandom_range(1, 24), $urandom_range(0, 1));
      r = $urandom_range(0, 9);
      if (r == 0) amt = {1'b1, 31'($urandom)};
      else if (r == 1) amt = 32'h7FFF_FFFF;
      else if (r == 2) amt = 32'd0;
      else amt = {1'b0, 31'($urandom)};
      queue_req(op, key, tag, amt, (n % 40 == 39), (n >= RANDOM_REQS - 30));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || table_replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d insert, %0d remove, %0d search, %0d list",
             reqs_taken, op_count[kit_pkg::OP_INSERT], op_count[kit_pkg::OP_REMOVE],
             op_count[kit_pkg::OP_SEARCH], op_count[kit_pkg::OP_LIST]);
    $display("%0d result words checked, %0d inserts rejected, %0d lookups missed",
             words_seen, rejects, misses);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/kit_pkg.sv
hdl/kit_ctrl.sv
hdl/kit_dp.sv
hdl/keyed_item_table_core.sv
hdl/kit_checker.sv
tb/testbench.sv
